// ----- design/bpa_pkg.sv -----
// Shared types and constants for the buddy page allocator.
package bpa_pkg;

    localparam int PageW  = 10;
    localparam int CountW = 16;
    localparam int CfgW   = 11;
    localparam int OrdW   = 5;

    // Managed frames and number of order lists
    localparam int NumPages = 1024;
    localparam int MaxOrder = 11;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SEED  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_BAD   = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // Per-page status codes
    localparam logic [1:0] PG_BODY = 2'd0;
    localparam logic [1:0] PG_USE  = 2'd1;
    localparam logic [1:0] PG_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CountW-1:0] page_count;
        logic [PageW-1:0]  page_index;
    } in_word_t;

    typedef struct packed {
        logic [PageW-1:0] granted_page;
        logic [1:0]       status;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CHK_RD,
        S_CHK,
        S_A_FIND,
        S_A_POP,
        S_UL_RD,
        S_UL_WR,
        S_SPLIT,
        S_AP_RD,
        S_AP_WR,
        S_REL,
        S_M_RD,
        S_M_CHK,
        S_HEAD,
        S_DONE
    } fsm_t;

endpackage

// ----- design/bpa_mem.sv -----
// Page-state and link memories: one write and one registered read port each.
module bpa_mem #(
    parameter int NumPages = 1024
) (
    input  logic                          aclk,
    input  logic [$clog2(NumPages)-1:0]   st_raddr,
    output logic [5:0]                    st_rdata,
    input  logic                          st_we,
    input  logic [$clog2(NumPages)-1:0]   st_waddr,
    input  logic [5:0]                    st_wdata,
    input  logic [$clog2(NumPages)-1:0]   nx_raddr,
    output logic [$clog2(NumPages)-1:0]   nx_rdata,
    input  logic                          nx_we,
    input  logic [$clog2(NumPages)-1:0]   nx_waddr,
    input  logic [$clog2(NumPages)-1:0]   nx_wdata,
    input  logic [$clog2(NumPages)-1:0]   pv_raddr,
    output logic [$clog2(NumPages)-1:0]   pv_rdata,
    input  logic                          pv_we,
    input  logic [$clog2(NumPages)-1:0]   pv_waddr,
    input  logic [$clog2(NumPages)-1:0]   pv_wdata
);
    localparam int AW = $clog2(NumPages);

    // status (upper 2 bits) and order (lower 4 bits) per page
    logic [5:0]    st_mem [NumPages];
    logic [AW-1:0] nx_mem [NumPages];
    logic [AW-1:0] pv_mem [NumPages];

    always_ff @(posedge aclk) begin
        if (st_we) st_mem[st_waddr] <= st_wdata;
        st_rdata <= st_mem[st_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
        nx_rdata <= nx_mem[nx_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
        pv_rdata <= pv_mem[pv_raddr];
    end
endmodule

// ----- design/buddy_page_allocator.sv -----
// Buddy page allocator top level: command sequencer around the page memories.
//
// One command is handled at a time. A zero-size, oversized or unknown
// command or an out-of-range index is answered straight from decode, and a free
// or seed of a page in the wrong state after one status read. A valid free
// or seed checks the buddy at each order and merges while it is free at equal
// order. An allocate searches the order lists upward and, if granted, splits
// down, listing each upper half still in range and dropping the others. The
// time per command grows with lists looked at, halves split off, buddies
// checked and merge levels, set by the one-read-per-cycle page memories. After
// reset a clearing pass zeroes the status memory; no command is accepted
// during it, configuration writes are taken as ever. A finished result sits
// in an output register; the next command is accepted at the edge at which
// that result is taken, or later.
module buddy_page_allocator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [10:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpa_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpa_pkg::out_word_t  m_data
);
    import bpa_pkg::*;

    localparam int NUM_PAGES = NumPages;
    localparam int MAX_ORDER = MaxOrder;
    localparam int AW = $clog2(NUM_PAGES);
    localparam int OW = $clog2(MAX_ORDER + 1);

    // configuration
    logic [CfgW-1:0] active_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) active_reg <= CfgW'(1024);
        else if (cfg_we) active_reg <= cfg_wdata;
    end

    // per-order list heads in flops
    logic [AW-1:0] first_reg [MAX_ORDER];
    logic [AW-1:0] last_reg  [MAX_ORDER];
    logic [MAX_ORDER-1:0] ne_reg;

    fsm_t state_reg, state_next;
    logic [AW:0] clr_reg;
    logic clr_busy;
    assign clr_busy = !clr_reg[AW];

    in_word_t  cmd_reg;
    out_word_t res_reg;
    logic      m_valid_reg;

    // working registers
    logic [OW-1:0] ord_reg, f_reg;
    logic [AW-1:0] chunk_reg, head_reg, node_reg;
    logic [OW-1:0] lo_reg;       // order of list in unlink/append
    logic [AW-1:0] nxv_reg, pvv_reg;
    logic [1:0]    ret_reg;      // who called unlink/append
    localparam logic [1:0] RET_POP = 2'd0, RET_SPLIT = 2'd1, RET_MERGE = 2'd2;

    // memory ports
    logic [AW-1:0] st_raddr, nx_raddr, pv_raddr, st_waddr, nx_waddr, pv_waddr;
    logic [AW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [5:0]    st_rdata, st_wdata;
    logic          st_we, nx_we, pv_we;

    bpa_mem #(.NumPages(NUM_PAGES)) u_mem (
        .aclk(aclk),
        .st_raddr(st_raddr), .st_rdata(st_rdata),
        .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
        .nx_raddr(nx_raddr), .nx_rdata(nx_rdata),
        .nx_we(nx_we), .nx_waddr(nx_waddr), .nx_wdata(nx_wdata),
        .pv_raddr(pv_raddr), .pv_rdata(pv_rdata),
        .pv_we(pv_we), .pv_waddr(pv_waddr), .pv_wdata(pv_wdata)
    );

    // range check on a page index
    function automatic logic in_rng(input logic [AW:0] i, input logic [CfgW-1:0] act);
        return (i < act) && (i < (AW+1)'(NUM_PAGES));
    endfunction

    // round page_count up to an order (one-level compare against powers)
    logic [OW:0] req_ord;
    always_comb begin
        req_ord = (OW+1)'(17);
        for (int k = 16; k >= 0; k--)
            if ((17'(1) << k) >= {1'b0, cmd_reg.page_count}) req_ord = (OW+1)'(k);
    end

    // buddy of current head at order ord_reg
    logic [AW:0]   bd_full;
    logic [AW-1:0] bd;
    assign bd_full = {1'b0, head_reg} ^ ((AW+1)'(1) << ord_reg);
    assign bd = bd_full[AW-1:0];

    // upper half split off the chunk at the next lower order
    logic [AW:0]   sb_full;
    assign sb_full = {1'b0, chunk_reg} ^ ((AW+1)'(1) << (f_reg - 1'b1));

    // unlink helpers
    logic is_first, is_last;
    assign is_first = first_reg[lo_reg[OW-1:0] < OW'(MAX_ORDER) ? lo_reg : '0] == node_reg;
    assign is_last  = last_reg[lo_reg < OW'(MAX_ORDER) ? lo_reg : '0] == node_reg;

    logic [OW-1:0] lo_i;
    assign lo_i = (lo_reg < OW'(MAX_ORDER)) ? lo_reg : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid && s_ready) state_next = S_DECODE;
            S_DECODE: begin
                unique case (cmd_reg.cmd) inside
                    CMD_ALLOC: state_next = (cmd_reg.page_count == '0 ||
                                             req_ord >= (OW+1)'(MAX_ORDER)) ? S_DONE : S_A_FIND;
                    CMD_FREE, CMD_SEED:
                        state_next = in_rng({1'b0, cmd_reg.page_index[AW-1:0]}, active_reg)
                                     ? S_CHK_RD : S_DONE;
                    default: state_next = S_DONE;
                endcase
            end
            S_CHK_RD: state_next = S_CHK;
            S_CHK: begin
                if ((cmd_reg.cmd == CMD_FREE && st_rdata[5:4] == PG_USE) ||
                    (cmd_reg.cmd == CMD_SEED && st_rdata[5:4] == PG_BODY))
                    state_next = S_REL;
                else
                    state_next = S_DONE;
            end
            S_A_FIND: begin
                if (f_reg >= OW'(MAX_ORDER)) state_next = S_DONE;
                else if (ne_reg[f_reg]) state_next = S_A_POP;
            end
            S_A_POP:  state_next = S_UL_RD;
            S_UL_RD:  state_next = S_UL_WR;
            S_UL_WR: begin
                unique case (ret_reg)
                    RET_POP:   state_next = S_SPLIT;
                    RET_MERGE: state_next = S_M_RD;
                    default:   state_next = S_SPLIT;
                endcase
            end
            S_SPLIT: begin
                // an upper half out of range is dropped without listing
                if (f_reg > ord_reg)
                    state_next = in_rng(sb_full, active_reg) ? S_AP_RD : S_SPLIT;
                else
                    state_next = S_DONE;
            end
            S_AP_RD:  state_next = S_AP_WR;
            S_AP_WR:  state_next = (ret_reg == RET_SPLIT) ? S_SPLIT : S_DONE;
            S_REL:    state_next = S_M_RD;
            S_M_RD:   state_next = ({1'b0, ord_reg} + 1'b1 < (OW+1)'(MAX_ORDER) &&
                                    in_rng(bd_full, active_reg)) ? S_M_CHK : S_HEAD;
            S_M_CHK:  state_next = (st_rdata[5:4] == PG_FREE &&
                                    st_rdata[3:0] == 4'(ord_reg)) ? S_UL_RD : S_HEAD;
            S_HEAD:   state_next = S_AP_RD;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        st_raddr = '0; nx_raddr = node_reg; pv_raddr = node_reg;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        if (clr_busy) begin
            st_we = 1'b1; st_waddr = clr_reg[AW-1:0];
        end
        unique case (state_reg)
            S_CHK_RD: st_raddr = cmd_reg.page_index[AW-1:0];
            S_M_RD:   st_raddr = bd;
            S_UL_WR: begin
                if (!(is_first && is_last)) begin
                    if (!is_first) begin
                        nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
                    end
                    if (!is_last) begin
                        pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
                    end
                end
                if (ret_reg == RET_MERGE) begin
                    st_we = 1'b1; st_waddr = node_reg; st_wdata = '0;
                end
            end
            S_REL: begin
                st_we = 1'b1; st_waddr = head_reg; st_wdata = '0;
            end
            S_AP_WR: begin
                // append node_reg to list lo_reg
                nx_we = 1'b1; nx_waddr = node_reg; nx_wdata = node_reg;
                pv_we = 1'b1; pv_waddr = node_reg;
                pv_wdata = ne_reg[lo_i] ? last_reg[lo_i] : node_reg;
                st_we = 1'b1; st_waddr = node_reg; st_wdata = {PG_FREE, 4'(lo_reg)};
            end
            S_AP_RD: begin
                if (ne_reg[lo_i]) begin
                    nx_we = 1'b1; nx_waddr = last_reg[lo_i]; nx_wdata = node_reg;
                end
            end
            S_DONE: begin
                if (cmd_reg.cmd == CMD_ALLOC && res_reg.status == ST_OK) begin
                    st_we = 1'b1; st_waddr = chunk_reg; st_wdata = {PG_USE, 4'(ord_reg)};
                end
            end
            default: ;
        endcase
    end

    // handshake
    assign s_ready = (state_reg == S_IDLE) && !clr_busy && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            clr_reg     <= '0;
            ne_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_busy) clr_reg <= clr_reg + 1'b1;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    cmd_reg <= s_data;
                    res_reg <= '{granted_page: '0, status: ST_BAD};
                end
                S_DECODE: begin
                    ord_reg  <= req_ord[OW-1:0];
                    f_reg    <= req_ord[OW-1:0];
                    head_reg <= cmd_reg.page_index[AW-1:0];
                    if (cmd_reg.cmd == CMD_ALLOC) begin
                        if (cmd_reg.page_count == '0) res_reg.status <= ST_ZERO;
                        else if (req_ord >= (OW+1)'(MAX_ORDER)) res_reg.status <= ST_NOMEM;
                    end
                end
                S_CHK: ord_reg <= (cmd_reg.cmd == CMD_FREE) ? OW'(st_rdata[3:0]) : '0;
                S_A_FIND: begin
                    if (f_reg >= OW'(MAX_ORDER)) res_reg.status <= ST_NOMEM;
                    else if (!ne_reg[f_reg]) f_reg <= f_reg + 1'b1;
                end
                S_A_POP: begin
                    chunk_reg <= last_reg[f_reg];
                    node_reg  <= last_reg[f_reg];
                    lo_reg    <= f_reg;
                    ret_reg   <= RET_POP;
                end
                S_UL_WR: begin
                    if (ne_reg[lo_i]) begin
                        if (is_first && is_last) ne_reg[lo_i] <= 1'b0;
                        else begin
                            if (is_first) first_reg[lo_i] <= nx_rdata;
                            if (is_last)  last_reg[lo_i]  <= pv_rdata;
                        end
                    end
                    if (ret_reg == RET_MERGE) begin
                        if (node_reg < head_reg) head_reg <= node_reg;
                        ord_reg <= ord_reg + 1'b1;
                    end
                end
                S_SPLIT: begin
                    if (f_reg > ord_reg) begin
                        f_reg    <= f_reg - 1'b1;
                        lo_reg   <= f_reg - 1'b1;
                        node_reg <= sb_full[AW-1:0];
                        ret_reg  <= RET_SPLIT;
                    end else begin
                        res_reg <= '{granted_page: PageW'(chunk_reg), status: ST_OK};
                    end
                end
                S_AP_WR: begin
                    if (!ne_reg[lo_i]) first_reg[lo_i] <= node_reg;
                    ne_reg[lo_i]   <= 1'b1;
                    last_reg[lo_i] <= node_reg;
                    if (ret_reg != RET_SPLIT) res_reg.status <= ST_OK;
                end
                S_M_CHK: begin
                    node_reg <= bd;
                    lo_reg   <= ord_reg;
                    ret_reg  <= RET_MERGE;
                end
                S_HEAD: begin
                    node_reg <= head_reg;
                    lo_reg   <= ord_reg;
                    ret_reg  <= RET_MERGE;
                end
                S_DONE: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // no command accepted during clearing pass
    a_no_acc_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !(s_valid && s_ready)) else $error("accept during clear");
    // result raised only from the done step
    a_res_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE)) else $error("stray result");
    // accepted command leaves idle next cycle
    a_acc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_DECODE) else $error("no decode");
`endif
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the buddy page allocator: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
    import bpa_pkg::*;

    localparam int NPAGES    = 1024;
    localparam int NORDERS   = 11;
    localparam int CYC_LIMIT = 1000000;
    localparam int DRAIN     = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;

    buddy_page_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the allocator state
    logic [1:0] pg_stat [NPAGES];
    logic [3:0] pg_ord  [NPAGES];
    int         fl_next [NPAGES];
    int         fl_prev [NPAGES];
    int         fl_head [NORDERS];
    int         fl_tail [NORDERS];
    bit         fl_busy [NORDERS];
    int         managed;

    out_word_t  grant_q [$];
    int         errors = 0;
    int         cycles = 0;
    bit         quiet = 1'b0;

    function automatic bit managed_page(int i);
        return i < managed && i < NPAGES;
    endfunction

    function automatic void fl_append(int o, int node);
        if (!fl_busy[o]) begin
            fl_head[o] = node;
            fl_prev[node] = node;
            fl_busy[o] = 1'b1;
        end else begin
            fl_next[fl_tail[o]] = node;
            fl_prev[node] = fl_tail[o];
        end
        fl_next[node] = node;
        fl_tail[o] = node;
    endfunction

    function automatic void fl_unlink(int o, int node);
        bit at_head, at_tail;
        if (!fl_busy[o]) return;
        at_head = (fl_head[o] == node);
        at_tail = (fl_tail[o] == node);
        if (at_head && at_tail) begin
            fl_busy[o] = 1'b0;
            return;
        end
        if (at_head) fl_head[o] = fl_next[node];
        else fl_next[fl_prev[node]] = fl_next[node];
        if (at_tail) fl_tail[o] = fl_prev[node];
        else fl_prev[fl_next[node]] = fl_prev[node];
    endfunction

    // Return a chunk to the pool, merging with free buddies of equal order
    function automatic void merge_release(int idx);
        int ord, head, bd;
        ord = pg_ord[idx];
        head = idx;
        pg_stat[idx] = PG_BODY;
        pg_ord[idx] = 0;
        while (ord + 1 < NORDERS) begin
            bd = head ^ (1 << ord);
            if (!managed_page(bd) || pg_ord[bd] != ord || pg_stat[bd] != PG_FREE) break;
            fl_unlink(ord, bd);
            pg_stat[bd] = PG_BODY;
            pg_ord[bd] = 0;
            if (bd < head) head = bd;
            ord++;
        end
        pg_stat[head] = PG_FREE;
        pg_ord[head] = ord[3:0];
        fl_append(ord, head);
    endfunction

    function automatic out_word_t predict_grant(in_word_t w);
        out_word_t r;
        int ord, f, chunk, bd;
        r.granted_page = '0;
        r.status = ST_BAD;
        case (w.cmd)
            CMD_ALLOC: begin
                if (w.page_count == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    ord = 0;
                    while ((1 << ord) < int'(w.page_count)) ord++;
                    f = ord;
                    while (f < NORDERS && !fl_busy[f]) f++;
                    if (f >= NORDERS) begin
                        r.status = ST_NOMEM;
                    end else begin
                        chunk = fl_tail[f];
                        fl_unlink(f, chunk);
                        // split down, listing each upper half still in range
                        while (f > ord) begin
                            f--;
                            bd = chunk ^ (1 << f);
                            if (managed_page(bd)) begin
                                pg_stat[bd] = PG_FREE;
                                pg_ord[bd] = f[3:0];
                                fl_append(f, bd);
                            end
                        end
                        pg_stat[chunk] = PG_USE;
                        pg_ord[chunk] = ord[3:0];
                        r.granted_page = chunk[PageW-1:0];
                        r.status = ST_OK;
                    end
                end
            end
            CMD_FREE: begin
                if (managed_page(int'(w.page_index)) && pg_stat[w.page_index] == PG_USE) begin
                    merge_release(int'(w.page_index));
                    r.status = ST_OK;
                end
            end
            CMD_SEED: begin
                if (managed_page(int'(w.page_index)) && pg_stat[w.page_index] == PG_BODY) begin
                    pg_ord[w.page_index] = 0;
                    merge_release(int'(w.page_index));
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // True when a body page lies inside some live chunk
    function automatic bit inside_chunk(int p);
        int h;
        for (int o = 0; o < NORDERS; o++) begin
            h = p & ~((1 << o) - 1);
            if (pg_stat[h] != PG_BODY && pg_ord[h] == o) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Find a page from a random start that matches the wanted status
    function automatic int pick_page(logic [1:0] want, bit fresh);
        int p;
        int start;
        start = $urandom_range(NPAGES - 1);
        for (int k = 0; k < NPAGES; k++) begin
            p = (start + k) % NPAGES;
            if (pg_stat[p] == want && (!fresh || (managed_page(p) && !inside_chunk(p))))
                return p;
        end
        return -1;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int sel, p;
        w.cmd = CMD_ALLOC;
        w.page_count = CountW'($urandom);
        w.page_index = PageW'($urandom);
        sel = $urandom_range(99);
        if (sel < 40) begin
            case ($urandom_range(9))
                0:       w.page_count = CountW'($urandom);
                1:       w.page_count = CountW'($urandom_range(1024, 1));
                2:       w.page_count = '0;
                default: w.page_count = CountW'($urandom_range(16, 1));
            endcase
        end else if (sel < 70) begin
            w.cmd = CMD_FREE;
            p = pick_page(PG_USE, 1'b0);
            if (p >= 0 && $urandom_range(9) != 0) w.page_index = PageW'(p);
        end else if (sel < 96) begin
            w.cmd = CMD_SEED;
            p = pick_page(PG_BODY, 1'b1);
            if (p >= 0 && $urandom_range(9) != 0) begin
                w.page_index = PageW'(p);
            end else begin
                // a rejected seed: a chunk head, or a page outside the managed range
                p = pick_page(PG_FREE, 1'b0);
                if (p < 0) p = pick_page(PG_USE, 1'b0);
                if (p >= 0) w.page_index = PageW'(p);
                else if (managed < NPAGES)
                    w.page_index = PageW'($urandom_range(NPAGES - 1, managed));
                else w.cmd = CMD_NONE;
            end
        end else begin
            w.cmd = CMD_NONE;
        end
        return w;
    endfunction

    // Send one word; the expected result is typed or predicted at acceptance
    task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
        int gap;
        out_word_t pred;
        gap = (!quiet && $urandom_range(7) == 0) ? $urandom_range(18, 1) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        pred = predict_grant(w);
        grant_q.insert(grant_q.size(), typed ? typed_res : pred);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_managed(int v);
        cfg_we <= 1'b1;
        cfg_wdata <= v[10:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        managed = v;
    endtask

    // Result side back-pressure in random bursts
    int stall_left = 0;
    always @(negedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(7) == 0) begin
            stall_left <= $urandom_range(17, 0);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h/%0d",
                         $time, m_data.granted_page, m_data.status);
                errors++;
            end else begin
                want = grant_q.pop_front();
                if (m_data.granted_page !== want.granted_page) begin
                    $display("%0t: granted_page expected %h actual %h",
                             $time, want.granted_page, m_data.granted_page);
                    errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("buddy_page_allocator test failed");
            $finish;
        end
    end

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t r;
    } stim_row_t;

    stim_row_t dir_rows [$];

    task automatic add_row(logic [1:0] c, int cnt, int idx, bit typed,
                           int gp, logic [1:0] st);
        stim_row_t row;
        row.w.cmd = c;
        row.w.page_count = cnt[CountW-1:0];
        row.w.page_index = idx[PageW-1:0];
        row.typed = typed;
        row.r.granted_page = gp[PageW-1:0];
        row.r.status = st;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial begin
        int phase_pages [7];
        out_word_t none;
        phase_pages = '{0, 600, 1, 1024, 777, 513, 1024};
        none = '0;
        for (int i = 0; i < NPAGES; i++) begin
            pg_stat[i] = PG_BODY;
            pg_ord[i] = 0;
            fl_next[i] = 0;
            fl_prev[i] = 0;
        end
        for (int o = 0; o < NORDERS; o++) begin
            fl_head[o] = 0;
            fl_tail[o] = 0;
            fl_busy[o] = 1'b0;
        end
        managed = NPAGES;

        // directed: empty pool, error codes, field extremes, split and merge
        add_row(CMD_ALLOC, 0, 0, 1, 0, ST_ZERO);
        add_row(CMD_NONE, 16'hffff, 1023, 1, 0, ST_BAD);
        add_row(CMD_ALLOC, 1, 0, 1, 0, ST_NOMEM);
        add_row(CMD_FREE, 0, 5, 1, 0, ST_BAD);
        add_row(CMD_SEED, 0, 0, 1, 0, ST_OK);
        add_row(CMD_SEED, 0, 1, 1, 0, ST_OK);
        add_row(CMD_SEED, 0, 0, 1, 0, ST_BAD);
        add_row(CMD_FREE, 0, 0, 1, 0, ST_BAD);
        add_row(CMD_SEED, 16'hffff, 1023, 1, 0, ST_OK);
        add_row(CMD_ALLOC, 1, 0, 0, 0, ST_OK);
        add_row(CMD_FREE, 0, 1023, 0, 0, ST_OK);
        add_row(CMD_ALLOC, 2, 0, 0, 0, ST_OK);
        add_row(CMD_ALLOC, 16'hffff, 0, 1, 0, ST_NOMEM);
        add_row(CMD_ALLOC, 1024, 0, 1, 0, ST_NOMEM);
        add_row(CMD_FREE, 0, 0, 0, 0, ST_OK);
        for (int i = 2; i < 8; i++) add_row(CMD_SEED, 0, i, 0, 0, ST_OK);
        add_row(CMD_ALLOC, 3, 0, 0, 0, ST_OK);
        add_row(CMD_ALLOC, 1, 0, 0, 0, ST_OK);
        add_row(CMD_FREE, 0, 4, 0, 0, ST_OK);
        add_row(CMD_FREE, 0, 0, 0, 0, ST_OK);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // random phases, one managed-page setting each
        foreach (phase_pages[ph]) begin
            wait_idle();
            write_managed(phase_pages[ph]);
            if (ph == 6) quiet = 1'b1;
            repeat (220) send_word(random_word(), 1'b0, none);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("buddy_page_allocator test passed");
        end else begin
            $display("buddy_page_allocator test failed");
        end
        $finish;
    end

endmodule
